FILE: hw/rtl/arsch_pkg.sv
`default_nettype none

package arsch_pkg;

   // Fixed field widths of the request and response
   localparam int AXIS_FIELD_W    = 3;
   localparam int STEP_W          = 16;
   localparam int TIME_W          = 32;
   localparam int QUANTUM_W       = 16;
   localparam int DUTY_W          = 16;
   localparam int OP_W            = 2;

   // Default axis count, quantum scale and width of quantum * scale
   localparam int NUM_AXES_DEFAULT = 8;
   localparam int QUANTUM_SCALE    = 1000;
   localparam int PROD_W           = 26;

   // Request op codes
   localparam logic [OP_W-1:0] OP_MOVE  = 2'd0;
   localparam logic [OP_W-1:0] OP_SCHED = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

   // Register byte addresses
   localparam logic [1:0] REG_SAFE_GAP = 2'd0;

   // Request class as decided by the front end
   typedef enum logic [1:0] {
      KIND_MOVE,
      KIND_SCHED,
      KIND_LOAD,
      KIND_NOP
   } kind_type;

   // One classified request waiting in the queue
   typedef struct packed {
      kind_type                  kind;
      logic [AXIS_FIELD_W-1:0]   axis;
      logic signed [STEP_W-1:0]  delta;
      logic [TIME_W-1:0]         now;
      logic [QUANTUM_W-1:0]      quantum;
      logic [DUTY_W-1:0]         duty_pos;
      logic [DUTY_W-1:0]         duty_neg;
   } entry_type;

   // Per-axis row held in the axis RAM
   typedef struct packed {
      logic signed [STEP_W-1:0]  pending;
      logic [TIME_W-1:0]         last_run;
      logic [QUANTUM_W-1:0]      quantum;
      logic [DUTY_W-1:0]         duty_pos;
      logic [DUTY_W-1:0]         duty_neg;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   // One response
   typedef struct packed {
      logic                      move_ok;
      logic                      found;
      logic [AXIS_FIELD_W-1:0]   axis_out;
      logic signed [STEP_W-1:0]  vector_left;
      logic [QUANTUM_W-1:0]      quantum_out;
      logic [DUTY_W-1:0]         duty_out;
      logic                      duty_write;
      logic                      pwm_on;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/arsch_ram.sv
`default_nettype none

module arsch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one port, read one port with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/arsch_front.sv
`default_nettype none

module arsch_front
   import arsch_pkg::*;
#(
   parameter int NUM_AXES = NUM_AXES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [OP_W-1:0]  req_tuser,
   input  wire logic [103:0]     req_tdata,
   output logic                  q_valid,
   output entry_type             q_entry,
   input  wire logic             q_pop
);

   localparam int QUEUE_DEPTH = 2;

   entry_type   entry_in;
   logic        axis_ok;
   logic        push;

   entry_type   q_mem_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   // Unpack the request and classify it
   always_comb begin
      axis_ok           = 32'(req_tdata[2:0]) < NUM_AXES;
      entry_in.axis     = req_tdata[2:0];
      entry_in.delta    = req_tdata[18:3];
      entry_in.now      = req_tdata[50:19];
      entry_in.quantum  = req_tdata[66:51];
      entry_in.duty_pos = req_tdata[82:67];
      entry_in.duty_neg = req_tdata[98:83];
      case (req_tuser)
         OP_MOVE:  entry_in.kind = axis_ok ? KIND_MOVE : KIND_NOP;
         OP_LOAD:  entry_in.kind = axis_ok ? KIND_LOAD : KIND_NOP;
         OP_SCHED: entry_in.kind = KIND_SCHED;
         default:  entry_in.kind = KIND_NOP;
      endcase
   end

   assign req_tready = count_ff != 2'(QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = count_ff != 2'd0;
   assign q_entry    = q_mem_ff[rd_ptr_ff];

   // Advance queue pointers and fill level
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/arsch_back.sv
`default_nettype none

module arsch_back
   import arsch_pkg::*;
#(
   parameter int NUM_AXES = NUM_AXES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [TIME_W-1:0]  safe_gap_us,
   input  wire logic               q_valid,
   input  wire entry_type          q_entry,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output result_type              rsp_result
);

   localparam int AXIS_W = $clog2(NUM_AXES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN,
      ST_GRANT,
      ST_COMMIT
   } state_type;

   state_type                 state_ff, state_in;
   entry_type                 cur_ff, cur_in;
   logic [AXIS_W-1:0]         scan_id_ff, scan_id_in;
   logic [AXIS_W-1:0]         hit_id_ff, hit_id_in;
   row_type                   hit_row_ff, hit_row_in;
   logic signed [STEP_W-1:0]  step_ff, step_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [QUANTUM_W-1:0]      granted_ff, granted_in;
   logic [DUTY_W-1:0]         duty_ff, duty_in;
   logic [AXIS_W-1:0]         last_served_ff, last_served_in;
   logic [DUTY_W-1:0]         applied_ff, applied_in;
   logic [NUM_AXES-1:0]       valid_ff, valid_in;
   logic                      rd_valid_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                rsp_ff, rsp_in;

   logic [AXIS_W-1:0]         rd_addr;
   logic [ROW_W-1:0]          rd_data;
   logic                      wr_en;
   logic [AXIS_W-1:0]         wr_addr;
   row_type                   wr_row;
   row_type                   row;
   logic signed [STEP_W:0]    sum;
   logic                      eligible;
   logic [AXIS_W-1:0]         scan_next;
   logic [AXIS_W-1:0]         item_addr;
   logic [AXIS_W-1:0]         start_next;
   logic [AXIS_W+AXIS_FIELD_W-1:0] axis_ext;
   logic [AXIS_W+AXIS_FIELD_W-1:0] hit_ext;

   function automatic logic [AXIS_W-1:0] next_axis(input logic [AXIS_W-1:0] id);
      next_axis = (id == AXIS_W'(NUM_AXES - 1)) ? '0 : id + 1'b1;
   endfunction

   arsch_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_AXES)
   ) u_axis_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Rows never written read as zero
   assign row = rd_valid_ff ? row_type'(rd_data) : '0;

   // Map between the 3-bit axis field and the RAM address
   assign axis_ext   = {{AXIS_W{1'b0}}, q_entry.axis};
   assign item_addr  = axis_ext[AXIS_W-1:0];
   assign hit_ext    = {{AXIS_FIELD_W{1'b0}}, hit_id_ff};
   assign scan_next  = next_axis(scan_id_ff);
   assign start_next = next_axis(last_served_ff);

   assign sum      = {row.pending[STEP_W-1], row.pending}
                   + {cur_ff.delta[STEP_W-1], cur_ff.delta};
   assign eligible = (row.pending != '0) && ((cur_ff.now - row.last_run) > safe_gap_us);

   assign q_pop = (state_ff == ST_IDLE) && q_valid && !rsp_valid_ff;

   // Pick the read address for the next cycle
   always_comb begin
      rd_addr = scan_next;
      if (state_ff == ST_IDLE) begin
         rd_addr = (q_entry.kind == KIND_SCHED) ? start_next : item_addr;
      end
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      scan_id_in     = scan_id_ff;
      hit_id_in      = hit_id_ff;
      hit_row_in     = hit_row_ff;
      step_in        = step_ff;
      prod_in        = prod_ff;
      granted_in     = granted_ff;
      duty_in        = duty_ff;
      last_served_in = last_served_ff;
      applied_in     = applied_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      wr_en          = 1'b0;
      wr_addr        = hit_id_ff;
      wr_row         = row;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               cur_in     = q_entry;
               scan_id_in = (q_entry.kind == KIND_SCHED) ? start_next : item_addr;
               case (q_entry.kind)
                  KIND_MOVE, KIND_LOAD: state_in = ST_MODIFY;
                  KIND_SCHED:           state_in = ST_SCAN;
                  default: begin
                     rsp_in          = '0;
                     rsp_in.duty_out = applied_ff;
                     rsp_valid_in    = 1'b1;
                  end
               endcase
            end
         end

         ST_MODIFY: begin
            // Read-modify-write the addressed axis row
            wr_en   = 1'b1;
            wr_addr = scan_id_ff;
            wr_row  = row;
            if (cur_ff.kind == KIND_MOVE) begin
               if (sum[STEP_W] != sum[STEP_W-1]) begin
                  wr_row.pending = sum[STEP_W] ? {1'b1, {(STEP_W-1){1'b0}}}
                                               : {1'b0, {(STEP_W-1){1'b1}}};
               end else begin
                  wr_row.pending = sum[STEP_W-1:0];
               end
            end else begin
               wr_row.quantum  = cur_ff.quantum;
               wr_row.duty_pos = cur_ff.duty_pos;
               wr_row.duty_neg = cur_ff.duty_neg;
            end
            valid_in[scan_id_ff] = 1'b1;
            rsp_in               = '0;
            rsp_in.move_ok       = 1'b1;
            rsp_in.duty_out      = applied_ff;
            rsp_valid_in         = 1'b1;
            state_in             = ST_IDLE;
         end

         ST_SCAN: begin
            // Test one axis per cycle, starting after the last one served
            scan_id_in = scan_next;
            if (eligible) begin
               hit_id_in  = scan_id_ff;
               hit_row_in = row;
               step_in    = row.pending[STEP_W-1] ? row.pending + STEP_W'(1)
                                                  : row.pending - STEP_W'(1);
               state_in   = ST_GRANT;
            end else if (scan_id_ff == last_served_ff) begin
               rsp_in          = '0;
               rsp_in.duty_out = applied_ff;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end

         ST_GRANT: begin
            // Pick duty and quantum, scale the quantum to microseconds
            duty_in    = step_ff[STEP_W-1] ? hit_row_ff.duty_neg : hit_row_ff.duty_pos;
            granted_in = ((step_ff != '0) && (hit_row_ff.quantum != '0))
                       ? hit_row_ff.quantum : '0;
            prod_in    = PROD_W'(granted_in) * PROD_W'(QUANTUM_SCALE);
            state_in   = ST_GRANT == state_ff ? ST_COMMIT : state_ff;
         end

         ST_COMMIT: begin
            wr_en              = 1'b1;
            wr_addr            = hit_id_ff;
            wr_row             = hit_row_ff;
            wr_row.pending     = step_ff;
            wr_row.last_run    = cur_ff.now + TIME_W'(prod_ff);
            valid_in[hit_id_ff] = 1'b1;
            last_served_in     = hit_id_ff;
            applied_in         = duty_ff;
            rsp_in             = '0;
            rsp_in.found       = 1'b1;
            rsp_in.axis_out    = hit_ext[AXIS_FIELD_W-1:0];
            rsp_in.vector_left = step_ff;
            rsp_in.quantum_out = granted_ff;
            rsp_in.duty_out    = duty_ff;
            rsp_in.duty_write  = duty_ff != applied_ff;
            rsp_in.pwm_on      = granted_ff != '0;
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, per-axis valid bits and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_served_ff <= '0;
         applied_ff     <= '0;
         valid_ff       <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_served_ff <= last_served_in;
         applied_ff     <= applied_in;
         valid_ff       <= valid_in;
         rd_valid_ff    <= valid_ff[rd_addr];
         rsp_valid_ff   <= rsp_valid_in;
      end
      cur_ff     <= cur_in;
      scan_id_ff <= scan_id_in;
      hit_id_ff  <= hit_id_in;
      hit_row_ff <= hit_row_in;
      step_ff    <= step_in;
      prod_ff    <= prod_in;
      granted_ff <= granted_in;
      duty_ff    <= duty_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/axis_round_robin_scheduler.sv
`default_nettype none

// Round-robin step scheduler over NUM_AXES motor axes. Requests carry the op
// in req_tuser (0 move, 1 schedule, 2 load settings); every request returns
// exactly one response, in order. A front end classifies requests into a
// two-entry queue; a back-end sequencer works one request at a time against
// a single-port-read axis RAM that holds each axis's pending count, last-run
// time, quantum and duties. A move or load is one read-modify-write of its
// axis row in ST_MODIFY. A schedule tests axes in ST_SCAN from the one after
// the last served: 1 to NUM_AXES of them if it grants an axis, then goes on
// through ST_GRANT and ST_COMMIT, or all NUM_AXES if it finds none eligible.
// The scan reads one axis row per cycle through the RAM's read port. The
// response is held in an output register until taken, while the queue keeps
// accepting until full, and the back end takes the next request the cycle
// after its response is taken. Axis rows read as zero after reset until first
// written; no clearing pass is needed. safe_gap_us sits at APB byte address 0
// and must only be written while the block is idle.
module axis_round_robin_scheduler
   import arsch_pkg::*;
#(
   parameter int NUM_AXES = NUM_AXES_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // Requests
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [1:0]    req_tuser,   // op
   input  wire logic [103:0]  req_tdata,   // axis, delta, now, quantum_ms, duty_pos, duty_neg
   // Responses
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [1:0]         rsp_tuser,   // move_ok, found
   output logic [55:0]        rsp_tdata,   // axis_out, vector_left, quantum_out, duty_out,
                                           // duty_write, pwm_on
   // Register port
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [1:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [TIME_W-1:0] safe_gap_ff, safe_gap_in;
   logic              q_valid;
   entry_type         q_entry;
   logic              q_pop;
   result_type        result;

   // Decode the hold-off register
   assign csr_pready = 1'b1;
   assign csr_prdata = safe_gap_ff;
   always_comb begin
      safe_gap_in = safe_gap_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && (csr_paddr == REG_SAFE_GAP)) begin
         safe_gap_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         safe_gap_ff <= '0;
      end else begin
         safe_gap_ff <= safe_gap_in;
      end
   end

   arsch_front #(
      .NUM_AXES (NUM_AXES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   arsch_back #(
      .NUM_AXES (NUM_AXES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .safe_gap_us (safe_gap_ff),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (result)
   );

   // Pack the response
   assign rsp_tuser = {result.found, result.move_ok};
   assign rsp_tdata = {3'b000, result.pwm_on, result.duty_write, result.duty_out,
                       result.quantum_out, result.vector_left, result.axis_out};

endmodule

`default_nettype wire

FILE: verif/tb.sv
module tb;
   import arsch_pkg::*;

   localparam int NAX = NUM_AXES_DEFAULT;
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER_REQ = 600;
   localparam int MAX_PRINT = 40;

   // One request as the sender sees it
   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [AXIS_FIELD_W-1:0]  axis;
      logic signed [STEP_W-1:0] delta;
      logic [TIME_W-1:0]        now;
      logic [QUANTUM_W-1:0]     quantum;
      logic [DUTY_W-1:0]        duty_pos;
      logic [DUTY_W-1:0]        duty_neg;
   } sched_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [1:0]    req_tuser = '0;   // op
   logic [103:0]  req_tdata = '0;   // axis, delta, now, quantum_ms, duty_pos, duty_neg
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [1:0]    rsp_tuser;        // move_ok, found
   logic [55:0]   rsp_tdata;        // axis_out, vector_left, quantum_out, duty_out,
                                    // duty_write, pwm_on
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [1:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   axis_round_robin_scheduler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Scheduler state as predicted
   logic [31:0]              gap_us = '0;
   logic signed [STEP_W-1:0] step_cnt [NAX] = '{default: '0};
   logic [TIME_W-1:0]        run_at [NAX] = '{default: '0};
   logic [QUANTUM_W-1:0]     quantum_tab [NAX] = '{default: '0};
   logic [DUTY_W-1:0]        duty_pos_tab [NAX] = '{default: '0};
   logic [DUTY_W-1:0]        duty_neg_tab [NAX] = '{default: '0};
   int unsigned              last_srv = 0;
   logic [DUTY_W-1:0]        cur_duty = '0;

   sched_req_type request_q [$];
   result_type    expected_rsp_q [$];
   sched_req_type cur_req;

   logic [TIME_W-1:0] t_us = '0;
   bit  req_took = 1'b0;
   bit  idle_on = 1'b0;
   bit  hold_active = 1'b0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  n_err = 0;
   int  n_req = 0;
   int  n_rsp = 0;
   int  n_grant = 0;
   int  n_empty = 0;
   int  n_dwrite = 0;
   int  n_sat = 0;
   int  n_gap_set = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      n_err++;
      if (n_err <= MAX_PRINT) $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic cmp_field(input string fld, input int unsigned got, input int unsigned want);
      if (got != want)
         flag_error($sformatf("response %0d field %s: got 0x%0h want 0x%0h",
                              n_rsp, fld, got, want));
   endtask

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Compute the response of one request and advance the predicted state
   function automatic result_type predict_response(input sched_req_type r);
      result_type res;
      int sum;
      int unsigned id;
      logic [TIME_W-1:0] idle;
      logic signed [STEP_W-1:0] v;
      logic [DUTY_W-1:0] duty;
      logic [QUANTUM_W-1:0] granted;
      logic [TIME_W-1:0] scaled;
      bit hit;
      res = '0;
      hit = 1'b0;
      case (r.op)
         OP_MOVE: begin
            if (r.axis < NAX) begin
               res.move_ok = 1'b1;
               sum = step_cnt[r.axis] + r.delta;
               if (sum > 32767 || sum < -32768) n_sat++;
               if (sum > 32767) sum = 32767;
               if (sum < -32768) sum = -32768;
               step_cnt[r.axis] = sum[STEP_W-1:0];
            end
         end
         OP_LOAD: begin
            if (r.axis < NAX) begin
               res.move_ok = 1'b1;
               quantum_tab[r.axis] = r.quantum;
               duty_pos_tab[r.axis] = r.duty_pos;
               duty_neg_tab[r.axis] = r.duty_neg;
            end
         end
         OP_SCHED: begin
            // scan starting after the last served axis
            for (int k = 1; k <= NAX && !hit; k++) begin
               id = (last_srv + k) % NAX;
               idle = r.now - run_at[id];
               if (step_cnt[id] != 0 && idle > gap_us) begin
                  hit = 1'b1;
                  v = STEP_W'((step_cnt[id] > 0) ? step_cnt[id] - 1 : step_cnt[id] + 1);
                  step_cnt[id] = v;
                  last_srv = id;
                  duty = (v < 0) ? duty_neg_tab[id] : duty_pos_tab[id];
                  if (duty != cur_duty) begin
                     cur_duty = duty;
                     res.duty_write = 1'b1;
                     n_dwrite++;
                  end
                  granted = (v != 0) ? quantum_tab[id] : '0;
                  scaled = 32'(granted) * 32'(QUANTUM_SCALE);
                  run_at[id] = r.now + scaled;
                  res.found = 1'b1;
                  res.axis_out = AXIS_FIELD_W'(id);
                  res.vector_left = v;
                  res.quantum_out = granted;
                  res.pwm_on = (granted != 0);
               end
            end
            if (hit) n_grant++;
            else n_empty++;
         end
         default: begin
         end
      endcase
      res.duty_out = cur_duty;
      return res;
   endfunction

   // Build a request with random filler in the fields its op ignores
   function automatic sched_req_type filler(input logic [OP_W-1:0] op);
      sched_req_type it;
      it.op = op;
      it.axis = AXIS_FIELD_W'($urandom_range(0, NAX - 1));
      it.delta = STEP_W'($urandom);
      it.now = $urandom;
      it.quantum = QUANTUM_W'($urandom);
      it.duty_pos = DUTY_W'($urandom);
      it.duty_neg = DUTY_W'($urandom);
      return it;
   endfunction

   task automatic push_move(input int a, input int d);
      sched_req_type it;
      it = filler(OP_MOVE);
      it.axis = AXIS_FIELD_W'(a);
      it.delta = STEP_W'(d);
      request_q.push_back(it);
   endtask

   task automatic push_sched(input logic [TIME_W-1:0] now);
      sched_req_type it;
      it = filler(OP_SCHED);
      it.now = now;
      request_q.push_back(it);
   endtask

   task automatic push_load(input int a, input int q, input int dp, input int dn);
      sched_req_type it;
      it = filler(OP_LOAD);
      it.axis = AXIS_FIELD_W'(a);
      it.quantum = QUANTUM_W'(q);
      it.duty_pos = DUTY_W'(dp);
      it.duty_neg = DUTY_W'(dn);
      request_q.push_back(it);
   endtask

   // Mostly well-formed traffic with advancing time, plus some noise
   task automatic gen_random(input int n);
      sched_req_type it;
      int r;
      int s;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            it = filler(OP_LOAD);
            s = $urandom_range(0, 99);
            if (s < 70) it.quantum = QUANTUM_W'($urandom_range(1, 30));
            else if (s < 82) it.quantum = '0;
            else if (s < 87) it.quantum = 16'hFFFF;
         end else if (r < 42) begin
            it = filler(OP_MOVE);
            s = $urandom_range(0, 99);
            if (s < 60) it.delta = STEP_W'(int'($urandom_range(0, 12)) - 6);
            else if (s < 85) it.delta = STEP_W'(int'($urandom_range(0, 600)) - 300);
         end else if (r < 96) begin
            it = filler(OP_SCHED);
            s = $urandom_range(0, 99);
            if (s < 70) t_us = t_us + $urandom_range(0, 40000);
            else if (s < 90) t_us = t_us + $urandom_range(0, 3000);
            else t_us = t_us + $urandom;
            it.now = t_us;
            // occasional unrelated timestamp
            if ($urandom_range(0, 19) == 0) it.now = $urandom;
         end else begin
            it = filler(OP_SPARE);
         end
         request_q.push_back(it);
      end
   endtask

   // Wait until every request is answered and the block has settled
   task automatic drain();
      while (request_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the hold-off register, then read it back
   task automatic csr_write(input logic [31:0] val);
      logic [31:0] rd;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= REG_SAFE_GAP;
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      gap_us = val;
      n_gap_set++;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_psel <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (rd !== val)
         flag_error($sformatf("safe_gap_us readback 0x%0h want 0x%0h", rd, val));
   endtask

   // Request driver: hold until taken, then insert a random gap if idle_on is set
   always @(negedge clock) begin : drive_req
      logic next_valid;
      next_valid = req_tvalid;
      if (!reset) begin
         if (req_tvalid && req_took) next_valid = 1'b0;
         if (!next_valid) begin
            if (gap_left > 0 && !hold_active) begin
               gap_left--;
            end else if (request_q.size() != 0) begin
               cur_req = request_q.pop_front();
               req_tuser <= cur_req.op;
               req_tdata <= {5'b0, cur_req.duty_neg, cur_req.duty_pos, cur_req.quantum,
                             cur_req.now, cur_req.delta, cur_req.axis};
               next_valid = 1'b1;
               gap_left = idle_on ? pick_gap() : 0;
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // Response receiver: random stalls when idle_on is set, or a long hold-off when asked
   always @(negedge clock) begin
      if (reset || hold_active) begin
         rsp_tready <= 1'b0;
      end else if (!idle_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Long output hold-off while requests keep coming
   initial begin
      while (n_req < HOLD_AFTER_REQ) @(posedge clock);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   // Monitor: predict on each request, check each response in order
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         req_took = 1'b0;
      end else begin
         req_took = req_tvalid && req_tready;
         if (req_took) begin
            expected_rsp_q.push_back(predict_response(cur_req));
            n_req++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               flag_error($sformatf("response %0d with nothing outstanding", n_rsp));
            end else begin
               want = expected_rsp_q.pop_front();
               cmp_field("move_ok", rsp_tuser[0], want.move_ok);
               cmp_field("found", rsp_tuser[1], want.found);
               cmp_field("axis_out", rsp_tdata[2:0], want.axis_out);
               cmp_field("vector_left", rsp_tdata[18:3], $unsigned(want.vector_left));
               cmp_field("quantum_out", rsp_tdata[34:19], want.quantum_out);
               cmp_field("duty_out", rsp_tdata[50:35], want.duty_out);
               cmp_field("duty_write", rsp_tdata[51], want.duty_write);
               cmp_field("pwm_on", rsp_tdata[52], want.pwm_on);
            end
            n_rsp++;
         end
      end
   end

   // Safety net against a hung block
   initial begin
      #10_000_000;
      $display("FAIL axis_round_robin_scheduler");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_write(32'd0);

      // Directed: saturation, a move back to zero, wrap of idle time, spare op
      push_sched(32'd0);
      push_load(0, 0, 16'hFFFF, 16'h0000);
      push_load(7, 16'hFFFF, 16'h1234, 16'hFFFF);
      push_load(3, 5, 16'h00AA, 16'h0055);
      push_move(7, 32767);
      push_move(7, 32767);
      push_move(3, -32768);
      push_move(3, -32768);
      push_move(0, 1);
      push_move(2, 3);
      push_move(2, -3);
      push_sched(32'd1);
      push_sched(32'd2);
      push_sched(32'd3);
      push_sched(32'd4);
      request_q.push_back(filler(OP_SPARE));
      push_sched(32'hFFFF_FFFF);
      push_move(5, -1);
      push_load(5, 1, 16'h0000, 16'h0000);
      push_sched(32'h8000_0000);
      push_sched(32'h8000_0000);
      push_sched(32'h0000_0000);
      drain();

      // Largest hold-off: nothing may be granted
      idle_on = 1'b1;
      csr_write(32'hFFFF_FFFF);
      gen_random(40);
      drain();

      csr_write(32'd1);
      gen_random(300);
      drain();

      csr_write(32'd5000);
      gen_random(600);
      drain();

      // Back-to-back traffic with no stalls on either side
      idle_on = 1'b0;
      csr_write($urandom_range(0, 20000));
      gen_random(300);
      drain();

      idle_on = 1'b1;
      csr_write(32'd0);
      gen_random(570);
      drain();

      $display("Ran %0d requests and %0d responses over %0d hold-off settings.",
               n_req, n_rsp, n_gap_set);
      $display("Grants %0d, empty scans %0d, duty updates %0d, saturated moves %0d.",
               n_grant, n_empty, n_dwrite, n_sat);
      if (n_err == 0) begin
         $display("PASS axis_round_robin_scheduler");
      end else begin
         $display("FAIL axis_round_robin_scheduler");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/arsch_pkg.sv
hw/rtl/arsch_ram.sv
hw/rtl/arsch_front.sv
hw/rtl/arsch_back.sv
hw/rtl/axis_round_robin_scheduler.sv
verif/tb.sv
